/* hdl/qau_pkg.sv */
package qau_pkg;

  localparam int CW = 16;
  localparam int FW = 12;
  localparam int PW = 2 * CW;
  localparam int MSW = 2 * CW + 2;
  localparam int SW = 2 * CW + 1;
  localparam int MW = CW + 1;
  localparam int QW = FW + 1;
  localparam int NW = CW + FW;
  localparam int DW = NW + 2;
  localparam int SQ_STEPS = MW;

  localparam logic [MW-1:0] MAG_MAX = MW'((2 ** (CW - 1)) - 1);
  localparam logic [QW-1:0] QUO_MAX = QW'(2 ** FW);

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_MUL  = 3'd1,
    CMD_CONJ = 3'd2,
    CMD_MAG  = 3'd3,
    CMD_NORM = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0]           cmd;
    logic signed [CW-1:0] a_re;
    logic signed [CW-1:0] a_i;
    logic signed [CW-1:0] a_j;
    logic signed [CW-1:0] a_k;
    logic signed [CW-1:0] b_re;
    logic signed [CW-1:0] b_i;
    logic signed [CW-1:0] b_j;
    logic signed [CW-1:0] b_k;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] r_re;
    logic signed [CW-1:0] r_i;
    logic signed [CW-1:0] r_j;
    logic signed [CW-1:0] r_k;
    logic                 overflow_flag;
  } out_t;

  typedef struct packed {
    logic [2:0]             cmd;
    logic [3:0][CW-1:0]     a;
    logic [3:0][CW-1:0]     r;
    logic                   flag;
  } ctx_t;

  typedef struct packed {
    logic [CW-1:0] v;
    logic          ovf;
  } sat_t;

  function automatic sat_t sat_wide(input logic signed [MSW-1:0] x);
    sat_t o;
    logic signed [MSW-1:0] hi;
    logic signed [MSW-1:0] lo;
    hi = {{(MSW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      o.v = hi[CW-1:0];
      o.ovf = 1'b1;
    end else if (x < lo) begin
      o.v = lo[CW-1:0];
      o.ovf = 1'b1;
    end else begin
      o.v = x[CW-1:0];
      o.ovf = 1'b0;
    end
    return o;
  endfunction

  function automatic sat_t round_sat(input logic signed [MSW-1:0] x);
    logic signed [MSW-1:0] t;
    t = x + (MSW'(1) <<< (FW - 1));
    return sat_wide(t >>> FW);
  endfunction

endpackage

/* hdl/quaternion_arith_unit_core.sv */
// quaternion arithmetic unit, signed q3.12 components
// request channel: req_valid / req_stall / req carry one transaction holding
// a command (add, multiply, conjugate, magnitude, normalize) and quaternions
// a and b. response channel: rsp_valid / rsp_stall / rsp carry the four
// saturated result components and the overflow flag, one per request.
// the pipeline takes one request every cycle while the response is not
// stalled. stages: two for products and sums, 17 for the square root (one
// result bit each) plus rounding, 14 for the four-lane normalize divider
// (a setup stage, then one quotient bit each), one output register.
// while rsp_valid is high and rsp_stall is high the whole pipeline holds and
// req_stall is high; nothing is dropped or repeated.
// reset clears all valid bits; no transaction is in flight afterwards and
// the unit accepts a request in the first cycle after reset.
module quaternion_arith_unit_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  qau_pkg::in_t  req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output qau_pkg::out_t rsp
);

  logic adv;
  logic f_valid;
  qau_pkg::ctx_t f_ctx;
  logic [qau_pkg::SW-1:0] f_sum;
  logic s_valid;
  qau_pkg::ctx_t s_ctx;
  logic [qau_pkg::MW-1:0] s_mag;
  logic d_valid;
  qau_pkg::ctx_t d_ctx;
  logic [qau_pkg::MW-1:0] d_mag;
  logic [3:0][qau_pkg::QW-1:0] d_quo;
  qau_pkg::out_t rsp_c;
  logic [3:0][qau_pkg::CW-1:0] r_c;
  logic [qau_pkg::CW-1:0] qv;

  assign adv = !rsp_valid || !rsp_stall;
  assign req_stall = !adv;

  qau_front u_front (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(req_valid), .req(req),
    .out_valid(f_valid), .out_ctx(f_ctx), .out_sum(f_sum)
  );

  qau_sqrt u_sqrt (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(f_valid), .in_ctx(f_ctx),
    .in_sum(f_sum), .out_valid(s_valid), .out_ctx(s_ctx), .out_mag(s_mag)
  );

  qau_div u_div (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(s_valid), .in_ctx(s_ctx),
    .in_mag(s_mag), .out_valid(d_valid), .out_ctx(d_ctx), .out_mag(d_mag),
    .out_quo(d_quo)
  );

  always_comb begin
    r_c = d_ctx.r;
    rsp_c.overflow_flag = d_ctx.flag;
    qv = '0;
    unique case (d_ctx.cmd)
      qau_pkg::CMD_MAG: begin
        r_c = '0;
        if (d_mag > qau_pkg::MAG_MAX) begin
          r_c[0] = qau_pkg::MAG_MAX[qau_pkg::CW-1:0];
          rsp_c.overflow_flag = 1'b1;
        end else begin
          r_c[0] = d_mag[qau_pkg::CW-1:0];
          rsp_c.overflow_flag = 1'b0;
        end
      end
      qau_pkg::CMD_NORM: begin
        r_c = '0;
        rsp_c.overflow_flag = (d_mag == '0);
        if (d_mag != '0) begin
          for (int n = 0; n < 4; n++) begin
            qv = qau_pkg::CW'(d_quo[n]);
            r_c[n] = d_ctx.a[n][qau_pkg::CW-1] ? -qv : qv;
          end
        end
      end
      default: begin
        r_c = d_ctx.r;
        rsp_c.overflow_flag = d_ctx.flag;
      end
    endcase
    rsp_c.r_re = r_c[0];
    rsp_c.r_i = r_c[1];
    rsp_c.r_j = r_c[2];
    rsp_c.r_k = r_c[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp <= rsp_c;
    end
  end

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

  a_mag_vector_zero: assert property (@(posedge clk) disable iff (rst)
    (adv && d_valid && d_ctx.cmd == qau_pkg::CMD_MAG) |=>
      (rsp_valid && rsp.r_i == '0 && rsp.r_j == '0 && rsp.r_k == '0))
    else $error("magnitude response with nonzero vector part");

  a_norm_quo_bound: assert property (@(posedge clk) disable iff (rst)
    (d_valid && d_ctx.cmd == qau_pkg::CMD_NORM && d_mag != '0) |->
      (d_quo[0] <= qau_pkg::QUO_MAX && d_quo[1] <= qau_pkg::QUO_MAX &&
       d_quo[2] <= qau_pkg::QUO_MAX && d_quo[3] <= qau_pkg::QUO_MAX))
    else $error("normalize quotient above one");

endmodule

/* hdl/qau_front.sv */
module qau_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  qau_pkg::in_t               req,
  output logic                       out_valid,
  output qau_pkg::ctx_t              out_ctx,
  output logic [qau_pkg::SW-1:0]     out_sum
);

  logic signed [qau_pkg::CW-1:0] av [4];
  logic signed [qau_pkg::CW-1:0] bv [4];
  logic [3:0][3:0][qau_pkg::PW-1:0] p_c;
  logic [3:0][qau_pkg::PW-1:0] sq_c;
  qau_pkg::ctx_t ctx_c;
  qau_pkg::sat_t st;

  logic valid1;
  qau_pkg::ctx_t ctx1;
  logic [3:0][3:0][qau_pkg::PW-1:0] p1;
  logic [3:0][qau_pkg::PW-1:0] sq1;

  always_comb begin
    av[0] = req.a_re;
    av[1] = req.a_i;
    av[2] = req.a_j;
    av[3] = req.a_k;
    bv[0] = req.b_re;
    bv[1] = req.b_i;
    bv[2] = req.b_j;
    bv[3] = req.b_k;
    ctx_c.cmd = req.cmd;
    ctx_c.r = '0;
    ctx_c.flag = 1'b0;
    st = '0;
    for (int n = 0; n < 4; n++) begin
      ctx_c.a[n] = av[n];
      sq_c[n] = av[n] * av[n];
      for (int m = 0; m < 4; m++) begin
        p_c[n][m] = av[n] * bv[m];
      end
    end
    if (req.cmd == qau_pkg::CMD_ADD) begin
      for (int n = 0; n < 4; n++) begin
        st = qau_pkg::sat_wide(qau_pkg::MSW'(av[n]) + qau_pkg::MSW'(bv[n]));
        ctx_c.r[n] = st.v;
        ctx_c.flag = ctx_c.flag | st.ovf;
      end
    end else if (req.cmd == qau_pkg::CMD_CONJ) begin
      ctx_c.r[0] = av[0];
      for (int n = 1; n < 4; n++) begin
        st = qau_pkg::sat_wide(-qau_pkg::MSW'(av[n]));
        ctx_c.r[n] = st.v;
        ctx_c.flag = ctx_c.flag | st.ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      valid1 <= in_valid;
      out_valid <= valid1;
    end
  end

  // products of the hamilton product, signed and summed exactly
  logic signed [qau_pkg::MSW-1:0] ms [4];
  qau_pkg::sat_t rs [4];
  qau_pkg::ctx_t ctx2_c;

  function automatic logic signed [qau_pkg::MSW-1:0] px(input logic [qau_pkg::PW-1:0] v);
    return qau_pkg::MSW'($signed(v));
  endfunction

  always_comb begin
    ms[0] = px(p1[0][0]) - px(p1[1][1]) - px(p1[2][2]) - px(p1[3][3]);
    ms[1] = px(p1[0][1]) + px(p1[1][0]) + px(p1[2][3]) - px(p1[3][2]);
    ms[2] = px(p1[0][2]) + px(p1[2][0]) + px(p1[3][1]) - px(p1[1][3]);
    ms[3] = px(p1[0][3]) + px(p1[3][0]) + px(p1[1][2]) - px(p1[2][1]);
    ctx2_c = ctx1;
    for (int n = 0; n < 4; n++) begin
      rs[n] = qau_pkg::round_sat(ms[n]);
    end
    if (ctx1.cmd == qau_pkg::CMD_MUL) begin
      for (int n = 0; n < 4; n++) begin
        ctx2_c.r[n] = rs[n].v;
      end
      ctx2_c.flag = rs[0].ovf | rs[1].ovf | rs[2].ovf | rs[3].ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx1 <= ctx_c;
      p1 <= p_c;
      sq1 <= sq_c;
      out_ctx <= ctx2_c;
      out_sum <= qau_pkg::SW'(sq1[0]) + qau_pkg::SW'(sq1[1])
               + qau_pkg::SW'(sq1[2]) + qau_pkg::SW'(sq1[3]);
    end
  end

endmodule

/* hdl/qau_sqrt.sv */
module qau_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  qau_pkg::ctx_t              in_ctx,
  input  logic [qau_pkg::SW-1:0]     in_sum,
  output logic                       out_valid,
  output qau_pkg::ctx_t              out_ctx,
  output logic [qau_pkg::MW-1:0]     out_mag
);

  localparam int N = qau_pkg::SQ_STEPS;

  logic                          vld [N];
  qau_pkg::ctx_t                 cx  [N];
  logic [qau_pkg::MSW-1:0]       rem [N];
  logic [qau_pkg::MSW-1:0]       res [N];

  // one result bit per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic [qau_pkg::MSW-1:0] BIT = qau_pkg::MSW'(1) << (2 * (N - 1 - i));
    logic                    v_in;
    qau_pkg::ctx_t           c_in;
    logic [qau_pkg::MSW-1:0] rem_in;
    logic [qau_pkg::MSW-1:0] res_in;
    logic [qau_pkg::MSW-1:0] trial;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign c_in = in_ctx;
      assign rem_in = qau_pkg::MSW'(in_sum);
      assign res_in = '0;
    end else begin : g_next
      assign v_in = vld[i-1];
      assign c_in = cx[i-1];
      assign rem_in = rem[i-1];
      assign res_in = res[i-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cx[i] <= c_in;
        if (rem_in >= trial) begin
          rem[i] <= rem_in - trial;
          res[i] <= (res_in >> 1) + BIT;
        end else begin
          rem[i] <= rem_in;
          res[i] <= res_in >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[N-1];
    end
  end

  // round to nearest
  always_ff @(posedge clk) begin
    if (adv) begin
      out_ctx <= cx[N-1];
      out_mag <= res[N-1][qau_pkg::MW-1:0]
               + qau_pkg::MW'(rem[N-1] > res[N-1]);
    end
  end

endmodule

/* hdl/qau_div.sv */
module qau_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  qau_pkg::ctx_t                       in_ctx,
  input  logic [qau_pkg::MW-1:0]              in_mag,
  output logic                                out_valid,
  output qau_pkg::ctx_t                       out_ctx,
  output logic [qau_pkg::MW-1:0]              out_mag,
  output logic [3:0][qau_pkg::QW-1:0]         out_quo
);

  localparam int N = qau_pkg::QW + 1;

  logic                                vld [N];
  qau_pkg::ctx_t                       cx  [N];
  logic [qau_pkg::MW-1:0]              mg  [N];
  logic [3:0][qau_pkg::DW-1:0]         rem [N];
  logic [3:0][qau_pkg::QW-1:0]         quo [N];

  logic [3:0][qau_pkg::DW-1:0] num_c;
  logic [qau_pkg::CW-1:0] mag_c;

  always_comb begin
    mag_c = '0;
    for (int n = 0; n < 4; n++) begin
      mag_c = in_ctx.a[n][qau_pkg::CW-1] ? -in_ctx.a[n] : in_ctx.a[n];
      num_c[n] = (qau_pkg::DW'(mag_c) << qau_pkg::FW) + qau_pkg::DW'(in_mag >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx[0] <= in_ctx;
      mg[0] <= in_mag;
      rem[0] <= num_c;
      quo[0] <= '0;
    end
  end

  // one quotient bit per stage, four lanes
  for (genvar i = 1; i < N; i++) begin : g_step
    logic [qau_pkg::DW-1:0] dsor;
    logic [3:0][qau_pkg::DW-1:0] rem_c;
    logic [3:0][qau_pkg::QW-1:0] quo_c;

    assign dsor = qau_pkg::DW'(mg[i-1]) << (N - 1 - i);

    always_comb begin
      for (int n = 0; n < 4; n++) begin
        if (rem[i-1][n] >= dsor) begin
          rem_c[n] = rem[i-1][n] - dsor;
          quo_c[n] = {quo[i-1][n][qau_pkg::QW-2:0], 1'b1};
        end else begin
          rem_c[n] = rem[i-1][n];
          quo_c[n] = {quo[i-1][n][qau_pkg::QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cx[i] <= cx[i-1];
        mg[i] <= mg[i-1];
        rem[i] <= rem_c;
        quo[i] <= quo_c;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign out_ctx = cx[N-1];
  assign out_mag = mg[N-1];
  assign out_quo = quo[N-1];

endmodule
